// ----- rtl/core/ppt_pkg.sv -----
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared widths, codes and types of the projective point transform unit.
// ----------------------------------------------------------------------------
package ppt_pkg;

	localparam int COORD_WIDTH    = 16;
	localparam int COEF_W         = 32;
	localparam int PROD_W         = COEF_W + COORD_WIDTH;
	localparam int SUM_W          = PROD_W + 2;
	localparam int FRAC_SHIFT     = 22;
	localparam int OFFSET_SHIFT   = 8;
	localparam int DEN_ONE_SHIFT  = 30;
	localparam int MAG_W          = SUM_W + FRAC_SHIFT;
	localparam int Q_W            = 32;
	localparam int BITS_PER_STAGE = 2;
	localparam int DIV_STAGES     = Q_W / BITS_PER_STAGE;
	localparam int DIV_LAT        = DIV_STAGES + 2;
	localparam int CFG_IDX_W      = 3;

	localparam logic [SUM_W-1:0] DEN_ONE = SUM_W'(1) << DEN_ONE_SHIFT;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} map_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A = 3'd0,
		REG_B = 3'd1,
		REG_C = 3'd2,
		REG_D = 3'd3,
		REG_E = 3'd4,
		REG_F = 3'd5,
		REG_G = 3'd6,
		REG_H = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] d;
		logic signed [COEF_W-1:0] e;
		logic signed [COEF_W-1:0] f;
		logic signed [COEF_W-1:0] g;
		logic signed [COEF_W-1:0] h;
	} coef_t;

	localparam coef_t COEF_RESET = '{
		a: 32'sd16777216, b: 32'sd0, c: 32'sd0, d: 32'sd0,
		e: 32'sd16777216, f: 32'sd0, g: 32'sd0, h: 32'sd0
	};

	typedef struct packed {
		logic signed [PROD_W-1:0] au;
		logic signed [PROD_W-1:0] bv;
		logic signed [PROD_W-1:0] du;
		logic signed [PROD_W-1:0] ev;
		logic signed [PROD_W-1:0] gu;
		logic signed [PROD_W-1:0] hv;
	} prod_t;

	typedef struct packed {
		logic [MAG_W-1:0] num;
		logic [SUM_W-1:0] den;
		logic             neg;
	} div_req_t;

	typedef struct packed {
		logic [Q_W-1:0] value;
		logic           sat;
	} div_res_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic zero;
	} ctl_t;

	typedef struct packed {
		map_status_t    status;
		logic           last;
		logic [Q_W-1:0] y;
		logic [Q_W-1:0] x;
	} out_t;

endpackage

// ----- rtl/core/ppt_mult.sv -----
// ----------------------------------------------------------------------------
// ppt_mult
// First stage: the six coefficient by coordinate products.
// ----------------------------------------------------------------------------
module ppt_mult (
	input  logic                                      clk,
	input  logic                                      en,
	input  logic signed [ppt_pkg::COORD_WIDTH-1:0]    u,
	input  logic signed [ppt_pkg::COORD_WIDTH-1:0]    v,
	input  ppt_pkg::coef_t                            coef,
	output ppt_pkg::prod_t                            prod_s1
);
	import ppt_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.au <= PROD_W'(coef.a * u);
			prod_s1.bv <= PROD_W'(coef.b * v);
			prod_s1.du <= PROD_W'(coef.d * u);
			prod_s1.ev <= PROD_W'(coef.e * v);
			prod_s1.gu <= PROD_W'(coef.g * u);
			prod_s1.hv <= PROD_W'(coef.h * v);
		end
	end

endmodule

// ----- rtl/core/ppt_div.sv -----
// ----------------------------------------------------------------------------
// ppt_div
// Pipelined restoring divider, two quotient bits per stage, with
// round-to-nearest and Q16.16 saturation.
// ----------------------------------------------------------------------------
module ppt_div (
	input  logic               clk,
	input  logic               en,
	input  ppt_pkg::div_req_t  req,
	output ppt_pkg::div_res_t  res_s
);
	import ppt_pkg::*;

	localparam int EXT_W = SUM_W + Q_W;
	localparam logic [Q_W:0] POS_MAX = ((Q_W+1)'(1) << (Q_W - 1)) - (Q_W+1)'(1);
	localparam logic [Q_W:0] NEG_MAX = (Q_W+1)'(1) << (Q_W - 1);

	logic [SUM_W-1:0] rem_s [0:DIV_STAGES];
	logic [Q_W-1:0]   low_s [0:DIV_STAGES];
	logic [SUM_W-1:0] den_s [0:DIV_STAGES];
	logic             neg_s [0:DIV_STAGES];
	logic             ovf_s [0:DIV_STAGES];

	function automatic logic [SUM_W+Q_W-1:0] div_step(
		input logic [SUM_W-1:0] rem_in,
		input logic [Q_W-1:0]   low_in,
		input logic [SUM_W-1:0] den
	);
		logic [SUM_W:0]   t;
		logic [SUM_W-1:0] r;
		logic [Q_W-1:0]   l;
		r = rem_in;
		l = low_in;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			t = {r, l[Q_W-1]};
			if (t >= {1'b0, den}) begin
				r = SUM_W'(t - {1'b0, den});
				l = {l[Q_W-2:0], 1'b1};
			end else begin
				r = t[SUM_W-1:0];
				l = {l[Q_W-2:0], 1'b0};
			end
		end
		return {r, l};
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= {{(EXT_W-MAG_W){1'b0}}, req.num} >= {req.den, {Q_W{1'b0}}};
			rem_s[0] <= SUM_W'(req.num[MAG_W-1:Q_W]);
			low_s[0] <= req.num[Q_W-1:0];
			den_s[0] <= req.den;
			neg_s[0] <= req.neg;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [SUM_W+Q_W-1:0] nxt;
		assign nxt = div_step(rem_s[k], low_s[k], den_s[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= nxt[SUM_W+Q_W-1:Q_W];
				low_s[k+1] <= nxt[Q_W-1:0];
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	logic           rnd;
	logic [Q_W:0]   qr;
	logic           sat;

	assign rnd = rem_s[DIV_STAGES] >= (den_s[DIV_STAGES] - rem_s[DIV_STAGES]);
	assign qr  = {1'b0, low_s[DIV_STAGES]} + (Q_W+1)'(rnd);
	assign sat = ovf_s[DIV_STAGES] || (neg_s[DIV_STAGES] ? (qr > NEG_MAX) : (qr > POS_MAX));

	always_ff @(posedge clk) begin
		if (en) begin
			res_s.sat <= sat;
			if (sat) begin
				res_s.value <= neg_s[DIV_STAGES] ? NEG_MAX[Q_W-1:0] : POS_MAX[Q_W-1:0];
			end else if (neg_s[DIV_STAGES]) begin
				res_s.value <= Q_W'(0) - qr[Q_W-1:0];
			end else begin
				res_s.value <= qr[Q_W-1:0];
			end
		end
	end

endmodule

// ----- rtl/core/ppt_skid.sv -----
// ----------------------------------------------------------------------------
// ppt_skid
// Output register with a spare entry; its ready is a register.
// ----------------------------------------------------------------------------
module ppt_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ppt_pkg::out_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ppt_pkg::out_t out_data
);
	import ppt_pkg::*;

	logic  out_valid_q;
	logic  spare_valid_q;
	out_t  out_data_q;
	out_t  spare_data_q;

	assign in_ready  = !spare_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (spare_valid_q) begin
			if (out_ready) begin
				spare_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= in_valid;
		end else if (in_valid) begin
			spare_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (spare_valid_q) begin
			if (out_ready) begin
				out_data_q <= spare_data_q;
			end
		end else if (!out_valid_q || out_ready) begin
			out_data_q <= in_data;
		end else begin
			spare_data_q <= in_data;
		end
	end

endmodule

// ----- rtl/core/projective_point_transform_unit.sv -----
// ----------------------------------------------------------------------------
// projective_point_transform_unit
// Maps source points through a programmable planar perspective transform.
// ----------------------------------------------------------------------------
// One point is taken every clock cycle while the skid buffer's spare entry is
// empty, and every point gives one result, in order, after passing through one
// product stage, one sum stage, one magnitude stage, the 18-stage divider (a
// range check, sixteen radix-4 restoring steps and a rounding stage) and the
// output register. The divider pipeline sets the latency. Write coefficients
// only while no point is in flight.
module projective_point_transform_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [31:0]                       s_axis_tdata,  // src_u, src_v
	input  logic                              s_axis_tlast,  // last_point
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [63:0]                       m_axis_tdata,  // dst_x, dst_y
	output logic [1:0]                        m_axis_tuser,  // map_status
	output logic                              m_axis_tlast,  // last_out
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppt_pkg::COEF_W-1:0]        cfg_data
);
	import ppt_pkg::*;

	coef_t  coef_q;
	logic   en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_A: coef_q.a <= cfg_data;
				REG_B: coef_q.b <= cfg_data;
				REG_C: coef_q.c <= cfg_data;
				REG_D: coef_q.d <= cfg_data;
				REG_E: coef_q.e <= cfg_data;
				REG_F: coef_q.f <= cfg_data;
				REG_G: coef_q.g <= cfg_data;
				REG_H: coef_q.h <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = en;

	prod_t prod_s1;
	logic  valid_s1, last_s1;

	ppt_mult u_mult (
		.clk     (clk),
		.en      (en),
		.u       (s_axis_tdata[COORD_WIDTH-1:0]),
		.v       (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.coef    (coef_q),
		.prod_s1 (prod_s1)
	);

	function automatic logic [SUM_W-1:0] sx_prod(input logic [PROD_W-1:0] p);
		return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
	endfunction

	function automatic logic [SUM_W-1:0] sx_off(input logic [COEF_W-1:0] c);
		return {{(SUM_W-COEF_W){c[COEF_W-1]}}, c} << OFFSET_SHIFT;
	endfunction

	logic [SUM_W-1:0] den_s2, numx_s2, numy_s2;
	logic             valid_s2, last_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s2  <= sx_prod(prod_s1.gu) + sx_prod(prod_s1.hv) + DEN_ONE;
			numx_s2 <= sx_prod(prod_s1.au) + sx_prod(prod_s1.bv) + sx_off(coef_q.c);
			numy_s2 <= sx_prod(prod_s1.du) + sx_prod(prod_s1.ev) + sx_off(coef_q.f);
		end
	end

	logic [SUM_W-1:0] dmag, xmag, ymag;
	logic             dneg, xneg, yneg;

	assign dneg = den_s2[SUM_W-1];
	assign xneg = numx_s2[SUM_W-1];
	assign yneg = numy_s2[SUM_W-1];
	assign dmag = dneg ? SUM_W'(0) - den_s2  : den_s2;
	assign xmag = xneg ? SUM_W'(0) - numx_s2 : numx_s2;
	assign ymag = yneg ? SUM_W'(0) - numy_s2 : numy_s2;

	div_req_t reqx_s3, reqy_s3;
	logic     zero_s3, valid_s3, last_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			reqx_s3 <= '{num: MAG_W'(xmag) << FRAC_SHIFT, den: dmag, neg: xneg ^ dneg};
			reqy_s3 <= '{num: MAG_W'(ymag) << FRAC_SHIFT, den: dmag, neg: yneg ^ dneg};
			zero_s3 <= (den_s2 == '0);
			last_s1 <= s_axis_tlast;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
		end
	end

	ctl_t ctl_q [0:DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				ctl_q[i] <= '0;
			end
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			ctl_q[0] <= '{valid: valid_s3, last: last_s3, zero: zero_s3};
			for (int i = 1; i < DIV_LAT; i++) begin
				ctl_q[i] <= ctl_q[i-1];
			end
		end
	end

	div_res_t resx, resy;

	ppt_div u_div_x (.clk(clk), .en(en), .req(reqx_s3), .res_s(resx));
	ppt_div u_div_y (.clk(clk), .en(en), .req(reqy_s3), .res_s(resy));

	out_t res_d, res_out;
	ctl_t ctl_end;

	assign ctl_end = ctl_q[DIV_LAT-1];

	always_comb begin
		res_d.last = ctl_end.last;
		if (ctl_end.zero) begin
			res_d.status = ST_ZERO;
			res_d.x      = '0;
			res_d.y      = '0;
		end else begin
			res_d.status = (resx.sat || resy.sat) ? ST_SAT : ST_OK;
			res_d.x      = resx.value;
			res_d.y      = resy.value;
		end
	end

	ppt_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ctl_end.valid),
		.in_ready  (en),
		.in_data   (res_d),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res_out)
	);

	assign m_axis_tdata = {res_out.y, res_out.x};
	assign m_axis_tuser = res_out.status;
	assign m_axis_tlast = res_out.last;

`ifndef ASSERT_OFF
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_ZERO |-> m_axis_tdata == '0)
		else $error("zero denominator result not cleared");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser == ST_OK || m_axis_tuser == ST_ZERO
			|| m_axis_tuser == ST_SAT)
		else $error("undefined status code");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_SAT |->
			m_axis_tdata[31:0] == 32'h7FFFFFFF || m_axis_tdata[31:0] == 32'h80000000
			|| m_axis_tdata[63:32] == 32'h7FFFFFFF || m_axis_tdata[63:32] == 32'h80000000)
		else $error("saturated result without limit value");
`endif

endmodule
